/* rtl/dn2cd_pkg.sv */
package dn2cd_pkg;

    localparam int unsigned JD_W    = 23;
    localparam int unsigned DAYS_W  = 22;
    localparam int unsigned N_W     = 31;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MON_W   = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned DBY_W   = 23;
    localparam int unsigned ND_W    = 24;
    localparam int unsigned SHIFT_Q = 48;

    localparam logic [JD_W-1:0] JD_OFFSET = 23'd1721425;
    localparam logic [JD_W-1:0] JD_LAST   = 23'd5373484;

    // days*10000/3652425 reduces to days*400/146097
    localparam logic [8:0]  DAY_SCALE = 9'd400;
    localparam logic [17:0] YEAR_DIV  = 18'd146097;

    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT_Q) + 64'd146097 - 64'd1) / 64'd146097;
    localparam logic [N_W-1:0] RECIP = RECIP_FULL[N_W-1:0];

    // x/100 as (x*5243)>>19, exact for 14-bit x
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    localparam logic [8:0]  DAYS_YEAR  = 9'd365;
    localparam logic [8:0]  DAYS_LEAP  = 9'd366;
    localparam logic signed [DBY_W-1:0] DBY_YEAR0 = -23'sd365;

    localparam logic [1:0] SEL_YEAR  = 2'd0;
    localparam logic [1:0] SEL_MONTH = 2'd1;
    localparam logic [1:0] SEL_DAY   = 2'd2;
    localparam logic [1:0] SEL_NONE  = 2'd3;

    localparam logic [8:0] MONTH_END [12] =
        '{9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
          9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
    localparam logic [8:0] MONTH_START [12] =
        '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
          9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

    typedef struct packed {
        logic       rng;
        logic [1:0] sel;
    } ctl_t;

    function automatic logic [YEAR_W-1:0] div100(input logic [YEAR_W-1:0] x);
        logic [26:0] pr;
        pr = 27'(x) * 27'(DIV100_MUL);
        return {6'd0, pr[26:19]};
    endfunction

    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] c;
        logic [YEAR_W-1:0] r;
        c = div100(y);
        r = y - YEAR_W'(c * 14'd100);
        return (y[1:0] == 2'b00 && r != '0) || (r == '0 && c[1:0] == 2'b00);
    endfunction

    // days before year p+1, p >= 0
    function automatic logic signed [DBY_W-1:0] dby_of(input logic [YEAR_W-1:0] p);
        logic [YEAR_W-1:0] c;
        logic [DBY_W-1:0]  acc;
        c   = div100(p);
        acc = DBY_W'(p) * DBY_W'(DAYS_YEAR) + DBY_W'(p >> 2) - DBY_W'(c)
            + DBY_W'(c >> 2);
        return $signed(acc);
    endfunction

endpackage

/* rtl/day_number_to_calendar_date_top.sv */
// Channel  | Beat fields (low bit first)                         | Handshake
// s_axis   | tdata: julian_day[22:0]; tuser: part_select[1:0]    | tvalid/tready
// m_axis   | tdata: year, month, day, selected; tuser: valid_res | tvalid/tready
//
// Seven register stages. One beat enters per cycle unless a stalled output
// fills every stage; the estimate multiply (31x31) sets the stage depth.
// Reset clears only the stage valid bits; no clearing pass, no table fill.
// Each stage advances when it is empty or the stage after it moves, so
// bubbles close up and a stalled output still lets earlier stages fill.
module day_number_to_calendar_date_top
    import dn2cd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // julian_day[22:0], zero pad
    input  logic [1:0]  s_axis_tuser,   // part_select[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // year[13:0], month[17:14], day[22:18],
                                        // selected_value[36:23], zero pad
    output logic [0:0]  m_axis_tuser    // valid_res
);

    localparam int unsigned NSTG = 7;

    logic [NSTG:1] vld_reg;
    logic [NSTG:1] vld_next;
    logic [NSTG:1] rdy;

    ctl_t ctl_s1_reg, ctl_s2_reg, ctl_s3_reg, ctl_s4_reg, ctl_s5_reg, ctl_s6_reg;
    ctl_t ctl_s1_next;

    logic [DAYS_W-1:0] days_s1_reg, days_s2_reg, days_s3_reg, days_s4_reg;
    logic [DAYS_W-1:0] days_s1_next;
    logic [N_W-1:0]    n_s1_reg, n_s2_reg;
    logic [N_W-1:0]    n_s1_next;
    logic [JD_W-1:0]   jd;
    logic [JD_W-1:0]   jd_off;

    logic [2*N_W-1:0]  prod;
    logic [YEAR_W-1:0] q0_s2_reg, q0_s2_next;
    logic [31:0]       chk;
    logic [YEAR_W-1:0] q_s3_reg, q_s3_next;
    logic [YEAR_W-1:0] q_s4_reg;
    logic signed [DBY_W-1:0] dbya_s4_reg, dbya_s4_next;
    logic signed [DBY_W-1:0] dbyb_s4_reg, dbyb_s4_next;

    logic signed [ND_W-1:0] days_s;
    logic signed [ND_W-1:0] nda;
    logic signed [ND_W-1:0] ndb;
    logic [YEAR_W-1:0]      year_s5_reg, year_s5_next;
    logic signed [ND_W-1:0] nd_s5_reg, nd_s5_next;

    logic                   leap0;
    logic                   leap1;
    logic signed [ND_W-1:0] maxd;
    logic [YEAR_W-1:0]      year_inc;
    logic [YEAR_W-1:0]      year_s6_reg, year_s6_next;
    logic signed [ND_W-1:0] nd_s6_reg, nd_s6_next;
    logic                   leap_s6_reg, leap_s6_next;

    logic signed [ND_W-1:0] lim [12];
    logic signed [ND_W-1:0] base;
    logic signed [ND_W-1:0] day_full;
    logic [MON_W-1:0]       mon;
    logic                   ok;
    logic [YEAR_W-1:0]      year_o;
    logic [MON_W-1:0]       mon_o;
    logic [DAY_W-1:0]       day_o;
    logic [YEAR_W-1:0]      sel_o;
    logic [39:0]            data_s7_reg, data_s7_next;
    logic                   user_s7_reg, user_s7_next;

    // stage handshake: a stage moves when empty or when its successor moves
    always_comb
    begin
        rdy[NSTG] = !vld_reg[NSTG] || m_axis_tready;
        for (int i = NSTG - 1; i >= 1; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        vld_next = vld_reg;
        if (rdy[1])
        begin
            vld_next[1] = s_axis_tvalid;
        end
        for (int i = 2; i <= NSTG; i++)
        begin
            if (rdy[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stage 1: range check, offset, scale
    always_comb
    begin
        jd               = s_axis_tdata[JD_W-1:0];
        jd_off           = jd - JD_OFFSET;
        days_s1_next     = jd_off[DAYS_W-1:0];
        n_s1_next        = N_W'(days_s1_next) * N_W'(DAY_SCALE);
        ctl_s1_next.rng  = (jd >= JD_OFFSET) && (jd <= JD_LAST);
        ctl_s1_next.sel  = s_axis_tuser;
    end

    // stage 2: reciprocal multiply for the year estimate
    always_comb
    begin
        prod       = (2*N_W)'(n_s1_reg) * (2*N_W)'(RECIP);
        q0_s2_next = prod[SHIFT_Q+YEAR_W-1:SHIFT_Q];
    end

    // stage 3: back off the quotient if the estimate overshot
    always_comb
    begin
        chk       = 32'(q0_s2_reg) * 32'(YEAR_DIV);
        q_s3_next = (chk > 32'(n_s2_reg)) ? q0_s2_reg - 1'b1 : q0_s2_reg;
    end

    // stage 4: year-start counts for the estimate and the year before it
    always_comb
    begin
        dbya_s4_next = dby_of(q_s3_reg);
        dbyb_s4_next = (q_s3_reg == '0) ? DBY_YEAR0 : dby_of(q_s3_reg - 1'b1);
    end

    // stage 5: correct the estimate down
    always_comb
    begin
        days_s = $signed({2'b00, days_s4_reg});
        nda    = days_s - ND_W'(dbya_s4_reg);
        ndb    = days_s - ND_W'(dbyb_s4_reg);
        if (nda <= 0)
        begin
            year_s5_next = q_s4_reg;
            nd_s5_next   = ndb;
        end
        else
        begin
            year_s5_next = q_s4_reg + 1'b1;
            nd_s5_next   = nda;
        end
    end

    // stage 6: fold overflow past the year length into the next year
    always_comb
    begin
        year_inc = year_s5_reg + 1'b1;
        leap0    = is_leap(year_s5_reg);
        leap1    = is_leap(year_inc);
        maxd     = leap0 ? $signed(ND_W'(DAYS_LEAP)) : $signed(ND_W'(DAYS_YEAR));
        if (nd_s5_reg > maxd)
        begin
            year_s6_next = year_inc;
            nd_s6_next   = nd_s5_reg - maxd;
            leap_s6_next = leap1;
        end
        else
        begin
            year_s6_next = year_s5_reg;
            nd_s6_next   = nd_s5_reg;
            leap_s6_next = leap0;
        end
    end

    // stage 7: month lookup and output packing
    always_comb
    begin
        for (int m = 0; m < 12; m++)
        begin
            lim[m] = $signed(ND_W'(MONTH_END[m]))
                   + $signed(ND_W'(leap_s6_reg && (m >= 1)));
        end
        mon  = '0;
        base = '0;
        // scan down so the first matching month wins
        for (int m = 11; m >= 0; m--)
        begin
            if (nd_s6_reg <= lim[m])
            begin
                mon  = MON_W'(m + 1);
                base = $signed(ND_W'(MONTH_START[m]))
                     + $signed(ND_W'(leap_s6_reg && (m >= 2)));
            end
        end
        day_full = nd_s6_reg - base;
        ok       = ctl_s6_reg.rng && (mon != '0) && (day_full >= 1);
        year_o   = ok ? year_s6_reg : '0;
        mon_o    = ok ? mon : '0;
        day_o    = ok ? day_full[DAY_W-1:0] : '0;
        unique case (ctl_s6_reg.sel)
            SEL_YEAR:  sel_o = year_o;
            SEL_MONTH: sel_o = YEAR_W'(mon_o);
            SEL_DAY:   sel_o = YEAR_W'(day_o);
            SEL_NONE:  sel_o = '0;
            default:   sel_o = '0;
        endcase
        data_s7_next = {3'b000, sel_o, day_o, mon_o, year_o};
        user_s7_next = ok;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            ctl_s1_reg  <= ctl_s1_next;
            days_s1_reg <= days_s1_next;
            n_s1_reg    <= n_s1_next;
        end
        if (rdy[2])
        begin
            ctl_s2_reg  <= ctl_s1_reg;
            days_s2_reg <= days_s1_reg;
            n_s2_reg    <= n_s1_reg;
            q0_s2_reg   <= q0_s2_next;
        end
        if (rdy[3])
        begin
            ctl_s3_reg  <= ctl_s2_reg;
            days_s3_reg <= days_s2_reg;
            q_s3_reg    <= q_s3_next;
        end
        if (rdy[4])
        begin
            ctl_s4_reg  <= ctl_s3_reg;
            days_s4_reg <= days_s3_reg;
            q_s4_reg    <= q_s3_reg;
            dbya_s4_reg <= dbya_s4_next;
            dbyb_s4_reg <= dbyb_s4_next;
        end
        if (rdy[5])
        begin
            ctl_s5_reg  <= ctl_s4_reg;
            year_s5_reg <= year_s5_next;
            nd_s5_reg   <= nd_s5_next;
        end
        if (rdy[6])
        begin
            ctl_s6_reg  <= ctl_s5_reg;
            year_s6_reg <= year_s6_next;
            nd_s6_reg   <= nd_s6_next;
            leap_s6_reg <= leap_s6_next;
        end
        if (rdy[7])
        begin
            data_s7_reg <= data_s7_next;
            user_s7_reg <= user_s7_next;
        end
    end

    assign s_axis_tready = rdy[1];
    assign m_axis_tvalid = vld_reg[NSTG];
    assign m_axis_tdata  = data_s7_reg;
    assign m_axis_tuser  = user_s7_reg;

endmodule

/* rtl/dn2cd_checker.sv */
module dn2cd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    logic [13:0] year_f;
    logic [3:0]  mon_f;
    logic [4:0]  day_f;
    logic [13:0] sel_f;

    assign year_f = m_axis_tdata[13:0];
    assign mon_f  = m_axis_tdata[17:14];
    assign day_f  = m_axis_tdata[22:18];
    assign sel_f  = m_axis_tdata[36:23];

    // rejected day numbers carry an all-zero beat
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("invalid result with nonzero fields");

    // converted dates fall in the calendar
    a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (mon_f >= 4'd1 && mon_f <= 4'd12 && day_f >= 5'd1 &&
             year_f <= 14'd9999 && m_axis_tdata[39:37] == 3'b000))
        else $error("converted date out of range");

    // the selected part is one of the date parts or zero
    a_sel_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (sel_f == '0 || sel_f == year_f || sel_f == 14'(mon_f) ||
             sel_f == 14'(day_f)))
        else $error("selected value matches no date part");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled beat changed");

endmodule

bind day_number_to_calendar_date_top dn2cd_checker u_dn2cd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* test/tb_day_number_to_calendar_date_top.sv */
`timescale 1ns / 100ps

module tb_day_number_to_calendar_date_top;
    import dn2cd_pkg::*;

    localparam int RANDOM_BEATS = 1900;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_AT      = 400;

    // days through the end of each month, common year
    localparam int MONTH_LAST [12] = '{31, 59, 90, 120, 151, 181,
                                       212, 243, 273, 304, 334, 365};

    typedef struct packed {
        logic        valid;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [13:0] picked;
    } date_result_t;

    typedef struct packed {
        logic [22:0]  jd;
        logic [1:0]   sel;
        logic         typed;
        date_result_t want;
    } probe_row_t;

    localparam date_result_t NO_DATE = '0;

    localparam probe_row_t PROBES [20] = '{
        '{23'd0,       SEL_YEAR,  1'b1, NO_DATE},
        '{23'd8388607, SEL_MONTH, 1'b1, NO_DATE},
        '{23'd1721424, SEL_DAY,   1'b1, NO_DATE},
        '{23'd5373485, SEL_NONE,  1'b1, NO_DATE},
        '{23'd1721425, SEL_MONTH, 1'b1, '{1'b1, 14'd0, 4'd12, 5'd30, 14'd12}},
        '{23'd1721425, SEL_YEAR,  1'b1, '{1'b1, 14'd0, 4'd12, 5'd30, 14'd0}},
        '{23'd5373484, SEL_DAY,   1'b1, '{1'b1, 14'd9999, 4'd12, 5'd31, 14'd31}},
        '{23'd5373484, SEL_YEAR,  1'b1, '{1'b1, 14'd9999, 4'd12, 5'd31, 14'd9999}},
        '{23'd5373484, SEL_NONE,  1'b1, '{1'b1, 14'd9999, 4'd12, 5'd31, 14'd0}},
        '{23'd1721426, SEL_YEAR,  1'b0, NO_DATE},
        '{23'd1721790, SEL_DAY,   1'b0, NO_DATE},
        '{23'd1721791, SEL_MONTH, 1'b0, NO_DATE},
        '{23'd2415079, SEL_DAY,   1'b0, NO_DATE},
        '{23'd2415080, SEL_MONTH, 1'b0, NO_DATE},
        '{23'd2451544, SEL_YEAR,  1'b0, NO_DATE},
        '{23'd2451545, SEL_NONE,  1'b0, NO_DATE},
        '{23'd2451604, SEL_DAY,   1'b0, NO_DATE},
        '{23'd2451605, SEL_MONTH, 1'b0, NO_DATE},
        '{23'd2451910, SEL_DAY,   1'b0, NO_DATE},
        '{23'd2451911, SEL_YEAR,  1'b0, NO_DATE}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // julian_day[22:0], zero pad
    logic [1:0]  s_axis_tuser = '0;   // part_select[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // year[13:0], month[17:14], day[22:18],
                                      // selected_value[36:23], zero pad
    logic [0:0]  m_axis_tuser;        // valid_res

    date_result_t pending_dates [$];
    int           mismatches = 0;
    int           beats_in = 0;
    int           hold_left = 0;
    bit           held_off = 1'b0;

    day_number_to_calendar_date_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic bit leap_year(input int y);
        return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
    endfunction

    // truncating division, so year 0 starts at -365
    function automatic int days_to_year_start(input int y);
        int p;
        p = y - 1;
        return p * 365 + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic date_result_t convert_day_number(input logic [22:0] jd,
                                                        input logic [1:0] sel);
        date_result_t r;
        int           days;
        int           yr;
        int           nd;
        int           span;
        int           mon;
        int           dom;
        int           base;
        int           bump;
        bit           lp;
        r   = '0;
        mon = 0;
        dom = 0;
        if (jd < JD_OFFSET || jd > JD_LAST)
            return r;
        days = int'(jd) - int'(JD_OFFSET);
        yr   = int'((longint'(days) * 10000) / 3652425) + 1;
        nd   = days - days_to_year_start(yr);
        if (nd <= 0)
        begin
            yr--;
            nd = days - days_to_year_start(yr);
        end
        span = leap_year(yr) ? 366 : 365;
        if (nd > span)
        begin
            yr++;
            nd -= span;
        end
        lp = leap_year(yr);
        for (int m = 0; m < 12; m++)
        begin
            bump = (lp && m >= 1) ? 1 : 0;
            if (mon == 0 && nd <= MONTH_LAST[m] + bump)
            begin
                base = 0;
                if (m > 0)
                    base = MONTH_LAST[m-1] + ((lp && m >= 2) ? 1 : 0);
                mon = m + 1;
                dom = nd - base;
            end
        end
        if (mon == 0 || dom < 1 || yr < 0 || yr > 16383)
            return r;
        r.valid = 1'b1;
        r.year  = yr[13:0];
        r.month = mon[3:0];
        r.day   = dom[4:0];
        case (sel)
            SEL_YEAR:  r.picked = r.year;
            SEL_MONTH: r.picked = 14'(r.month);
            SEL_DAY:   r.picked = 14'(r.day);
            default:   r.picked = '0;
        endcase
        return r;
    endfunction

    function automatic bit steady_window();
        return beats_in >= 900 && beats_in < 1250;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic push_beat(input logic [22:0] jd, input logic [1:0] sel,
                             input date_result_t want);
        while (!steady_window() && $urandom_range(99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, jd};
        s_axis_tuser  <= sel;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_dates.push_back(want);
        beats_in++;
    endtask

    initial
    begin
        logic [22:0] jd;
        logic [1:0]  sel;
        int          nudge;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (PROBES[i])
            push_beat(PROBES[i].jd, PROBES[i].sel,
                      PROBES[i].typed ? PROBES[i].want
                                      : convert_day_number(PROBES[i].jd, PROBES[i].sel));
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            sel = 2'($urandom_range(3));
            case ($urandom_range(9))
                0, 1: jd = 23'($urandom_range(8388607));
                2:
                begin
                    // land on either side of the valid window
                    nudge = int'($urandom_range(16)) - 8;
                    jd = ($urandom_range(1) != 0) ? 23'(int'(JD_OFFSET) + nudge)
                                                  : 23'(int'(JD_LAST) + nudge);
                end
                default: jd = 23'($urandom_range(JD_LAST, JD_OFFSET));
            endcase
            push_beat(jd, sel, convert_day_number(jd, sel));
        end
        s_axis_tvalid <= 1'b0;
        while (pending_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random stalls, one long hold-off while the sender keeps pushing
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!held_off && beats_in >= HOLD_AT)
        begin
            held_off      <= 1'b1;
            hold_left     <= HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= steady_window() || $urandom_range(99) >= 12;
    end

    always @(posedge clk)
    begin : check_results
        date_result_t seen;
        date_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.valid  = m_axis_tuser[0];
            seen.year   = m_axis_tdata[13:0];
            seen.month  = m_axis_tdata[17:14];
            seen.day    = m_axis_tdata[22:18];
            seen.picked = m_axis_tdata[36:23];
            if (pending_dates.size() == 0)
                report_mismatch("beat with nothing pending, year", seen.year, -1);
            else
            begin
                want = pending_dates.pop_front();
                if (seen.valid !== want.valid)
                    report_mismatch("valid_res", seen.valid, want.valid);
                if (seen.year !== want.year)
                    report_mismatch("year_out", seen.year, want.year);
                if (seen.month !== want.month)
                    report_mismatch("month_out", seen.month, want.month);
                if (seen.day !== want.day)
                    report_mismatch("day_out", seen.day, want.day);
                if (seen.picked !== want.picked)
                    report_mismatch("selected_value", seen.picked, want.picked);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready)
                       || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
